### sv/length_prefixed_message_deframer_assert.svh
// Assertion macros for the length-prefixed message deframer.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LPMD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deframer assertion failed");

// Condition must never be seen outside reset.
`define LPMD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("deframer forbidden condition seen");

`else

`define LPMD_ASSERT(lbl, clk, rstn, prop)
`define LPMD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### sv/lpmd_pkg.sv
// Package: types, constants and type-letter decode for the deframer.
`default_nettype none

package lpmd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KIND_W = 5;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd20;

    // Framing phase
    typedef enum logic [1:0] {
        PH_LEN_HIGH = 2'd0,
        PH_LEN_LOW  = 2'd1,
        PH_PAYLOAD  = 2'd2
    } phase_t;

    // Framing state carried between items
    typedef struct packed {
        phase_t              phase;
        logic [BYTE_W-1:0]   length_high;
        logic [LEN_W-1:0]    current_length;
        logic [LEN_W-1:0]    payload_position;
        logic [KIND_W-1:0]   kind_held;
    } state_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic [KIND_W-1:0]   message_kind;
        logic [LEN_W-1:0]    byte_offset;
        logic [LEN_W-1:0]    message_length;
        logic                first_flag;
        logic                last_flag;
    } result_t;

    // Type letter to kind code
    function automatic logic [KIND_W-1:0] letter_to_kind(input logic [BYTE_W-1:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            8'h53:   k = 5'd0;   // S
            8'h52:   k = 5'd1;   // R
            8'h48:   k = 5'd2;   // H
            8'h59:   k = 5'd3;   // Y
            8'h4C:   k = 5'd4;   // L
            8'h56:   k = 5'd5;   // V
            8'h57:   k = 5'd6;   // W
            8'h4B:   k = 5'd7;   // K
            8'h41:   k = 5'd8;   // A
            8'h46:   k = 5'd9;   // F
            8'h45:   k = 5'd10;  // E
            8'h43:   k = 5'd11;  // C
            8'h58:   k = 5'd12;  // X
            8'h44:   k = 5'd13;  // D
            8'h55:   k = 5'd14;  // U
            8'h50:   k = 5'd15;  // P
            8'h51:   k = 5'd16;  // Q
            8'h42:   k = 5'd17;  // B
            8'h49:   k = 5'd18;  // I
            8'h4E:   k = 5'd19;  // N
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### sv/length_prefixed_message_deframer.sv
// Top level of the length-prefixed message deframer.
// Takes one stream byte per item and accepts a new item every cycle under
// steady flow. Each message is a 2-byte big-endian length and then that many
// payload bytes; length bytes and zero-length prefixes give no result, and
// every payload byte gives one result item carrying its offset, the message
// length, first/last marks and the type code decoded from the first byte.
// An accepted byte sits in an input register, passes one level of framing
// logic and lands in the result register. Throughput is one byte per cycle,
// set by the framing state update; it drops only while the result register
// is held by m_ready low.
`default_nettype none

module length_prefixed_message_deframer (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [lpmd_pkg::BYTE_W-1:0]      s_data_byte,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [lpmd_pkg::BYTE_W-1:0]     m_payload_byte,
    output logic [lpmd_pkg::KIND_W-1:0]     m_message_kind,
    output logic [lpmd_pkg::LEN_W-1:0]      m_byte_offset,
    output logic [lpmd_pkg::LEN_W-1:0]      m_message_length,
    output logic                            m_first_flag,
    output logic                            m_last_flag
);

`include "length_prefixed_message_deframer_assert.svh"

    logic                        in_valid_reg;
    logic [lpmd_pkg::BYTE_W-1:0] in_byte_reg;
    lpmd_pkg::state_t            state_reg;
    lpmd_pkg::state_t            state_next;
    logic                        out_valid_reg;
    lpmd_pkg::result_t           out_reg;
    logic                        step_emit;
    lpmd_pkg::result_t           step_result;
    logic                        advance;

    lpmd_step u_step (
        .state_cur  (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Held byte moves on when it yields nothing or the result slot frees up
    assign advance = in_valid_reg && (!step_emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase            <= lpmd_pkg::PH_LEN_HIGH;
            state_reg.length_high      <= '0;
            state_reg.current_length   <= '0;
            state_reg.payload_position <= '0;
            state_reg.kind_held        <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_emit) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_message_kind   = out_reg.message_kind;
    assign m_byte_offset    = out_reg.byte_offset;
    assign m_message_length = out_reg.message_length;
    assign m_first_flag     = out_reg.first_flag;
    assign m_last_flag      = out_reg.last_flag;

    // Checks
    `LPMD_ASSERT(a_first_at_zero, aclk, aresetn,
        (m_valid && m_first_flag) |-> (m_byte_offset == '0))
    `LPMD_ASSERT(a_last_at_end, aclk, aresetn,
        (m_valid && m_last_flag) |-> ({1'b0, m_byte_offset} + 17'd1 == {1'b0, m_message_length}))
    `LPMD_ASSERT(a_offset_in_range, aclk, aresetn,
        m_valid |-> (m_byte_offset < m_message_length))
    `LPMD_ASSERT_NEVER(a_payload_len_zero, aclk, aresetn,
        (state_reg.phase == lpmd_pkg::PH_PAYLOAD) && (state_reg.current_length == '0))

endmodule

`default_nettype wire

### sv/lpmd_step.sv
// Per-byte framing step: next state and optional result for one stream byte.
`default_nettype none

module lpmd_step (
    input  wire lpmd_pkg::state_t          state_cur,
    input  wire [lpmd_pkg::BYTE_W-1:0]     data_byte,
    output lpmd_pkg::state_t               state_next,
    output logic                           emit,
    output lpmd_pkg::result_t              result
);

    logic [lpmd_pkg::LEN_W-1:0]  len;
    logic [lpmd_pkg::LEN_W:0]    pos_inc;
    logic                        first;
    logic                        last;
    logic [lpmd_pkg::KIND_W-1:0] kind;

    // Length assembly and position arithmetic
    always_comb begin
        len     = {state_cur.length_high, data_byte};
        pos_inc = {1'b0, state_cur.payload_position} + 17'd1;
        first   = (state_cur.payload_position == '0);
        last    = (pos_inc >= {1'b0, state_cur.current_length});
        kind    = first ? lpmd_pkg::letter_to_kind(data_byte) : state_cur.kind_held;
    end

    // Phase handling
    always_comb begin
        state_next = state_cur;
        emit       = 1'b0;

        result.payload_byte   = data_byte;
        result.message_kind   = kind;
        result.byte_offset    = state_cur.payload_position;
        result.message_length = state_cur.current_length;
        result.first_flag     = first;
        result.last_flag      = last;

        case (state_cur.phase)
            lpmd_pkg::PH_LEN_LOW: begin
                if (len == '0) begin
                    // empty message is dropped
                    state_next.phase = lpmd_pkg::PH_LEN_HIGH;
                end else begin
                    state_next.current_length   = len;
                    state_next.payload_position = '0;
                    state_next.phase            = lpmd_pkg::PH_PAYLOAD;
                end
            end
            lpmd_pkg::PH_PAYLOAD: begin
                if (state_cur.current_length == '0) begin
                    state_next.length_high = data_byte;
                    state_next.phase       = lpmd_pkg::PH_LEN_LOW;
                end else begin
                    emit                = 1'b1;
                    state_next.kind_held = kind;
                    if (last) begin
                        state_next.phase            = lpmd_pkg::PH_LEN_HIGH;
                        state_next.payload_position = '0;
                    end else begin
                        state_next.payload_position = pos_inc[lpmd_pkg::LEN_W-1:0];
                    end
                end
            end
            default: begin
                // high length byte, also the unused phase code
                state_next.length_high = data_byte;
                state_next.phase       = lpmd_pkg::PH_LEN_LOW;
            end
        endcase
    end

endmodule

`default_nettype wire
